// ===== src/assert_macros.svh =====
// Assertion macros shared by the readout design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset.
`define MCASR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that cond never holds at a rising clock edge outside reset.
`define MCASR_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/mcasr_pkg.sv =====
// Shared constants, types and codes of the converter readout sequencer.
package mcasr_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int TIMER_BITS   = 16;
    localparam int CH_BITS      = $clog2(MAX_CHANNELS);
    localparam int CNT_BITS     = 4;
    localparam int PULSE_BITS   = 5;
    localparam int TRAIL_BITS   = 2;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;
    localparam int LINE_BITS    = 8;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 32;
    localparam int M_TUSER_W    = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETUP,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [1:0] {
        ST_PLAIN   = 2'd0,
        ST_WORD    = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_CHANNEL_COUNT   = 3'd0,
        REG_HIGH_TICKS      = 3'd1,
        REG_LOW_TICKS       = 3'd2,
        REG_SAMPLE_TICKS    = 3'd3,
        REG_SETUP_TICKS     = 3'd4,
        REG_TRAILING_PULSES = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_BITS-1:0]   channel_count;
        logic [TIMER_BITS-1:0] high_ticks;
        logic [TIMER_BITS-1:0] low_ticks;
        logic [TIMER_BITS-1:0] sample_ticks;
        logic [TIMER_BITS-1:0] setup_ticks;
        logic [TRAIL_BITS-1:0] trailing_pulses;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_lane_ctl;

    typedef struct packed {
        logic                serial_clock;
        logic                busy;
        t_status             status;
        logic                burst;
        logic [CNT_BITS-1:0] n;
    } t_tick_res;

endpackage

// ===== src/mcasr_regs.sv =====
// Configuration register file behind the APB-style port.
module mcasr_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcasr_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [mcasr_pkg::DATA_BITS-1:0]   pwdata,
    output logic [mcasr_pkg::DATA_BITS-1:0]   prdata,
    output logic                              pready,
    output mcasr_pkg::t_cfg                   o_cfg
);

    localparam int ADDR_HI = mcasr_pkg::ADDR_BITS - 1;

    mcasr_pkg::t_cfg    r_cfg;
    mcasr_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx  = mcasr_pkg::t_reg_idx'(paddr[ADDR_HI:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count   <= mcasr_pkg::CNT_BITS'(1);
            r_cfg.high_ticks      <= mcasr_pkg::TIMER_BITS'(3);
            r_cfg.low_ticks       <= mcasr_pkg::TIMER_BITS'(3);
            r_cfg.sample_ticks    <= mcasr_pkg::TIMER_BITS'(2);
            r_cfg.setup_ticks     <= mcasr_pkg::TIMER_BITS'(2);
            r_cfg.trailing_pulses <= mcasr_pkg::TRAIL_BITS'(3);
        end else if (w_wr) begin
            unique case (w_idx)
                mcasr_pkg::REG_CHANNEL_COUNT:
                    r_cfg.channel_count <= pwdata[mcasr_pkg::CNT_BITS-1:0];
                mcasr_pkg::REG_HIGH_TICKS:
                    r_cfg.high_ticks <= pwdata[mcasr_pkg::TIMER_BITS-1:0];
                mcasr_pkg::REG_LOW_TICKS:
                    r_cfg.low_ticks <= pwdata[mcasr_pkg::TIMER_BITS-1:0];
                mcasr_pkg::REG_SAMPLE_TICKS:
                    r_cfg.sample_ticks <= pwdata[mcasr_pkg::TIMER_BITS-1:0];
                mcasr_pkg::REG_SETUP_TICKS:
                    r_cfg.setup_ticks <= pwdata[mcasr_pkg::TIMER_BITS-1:0];
                mcasr_pkg::REG_TRAILING_PULSES:
                    r_cfg.trailing_pulses <= pwdata[mcasr_pkg::TRAIL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            mcasr_pkg::REG_CHANNEL_COUNT:
                prdata = mcasr_pkg::DATA_BITS'(r_cfg.channel_count);
            mcasr_pkg::REG_HIGH_TICKS:
                prdata = mcasr_pkg::DATA_BITS'(r_cfg.high_ticks);
            mcasr_pkg::REG_LOW_TICKS:
                prdata = mcasr_pkg::DATA_BITS'(r_cfg.low_ticks);
            mcasr_pkg::REG_SAMPLE_TICKS:
                prdata = mcasr_pkg::DATA_BITS'(r_cfg.sample_ticks);
            mcasr_pkg::REG_SETUP_TICKS:
                prdata = mcasr_pkg::DATA_BITS'(r_cfg.setup_ticks);
            mcasr_pkg::REG_TRAILING_PULSES:
                prdata = mcasr_pkg::DATA_BITS'(r_cfg.trailing_pulses);
            default: prdata = '0;
        endcase
    end

endmodule

// ===== src/mcasr_lane.sv =====
// One channel lane: the 24-bit shift word of a single converter data line.
module mcasr_lane (
    input  logic                                i_clk,
    input  mcasr_pkg::t_lane_ctl                i_ctl,
    input  logic                                i_bit,
    output logic [mcasr_pkg::SAMPLE_BITS-1:0]   o_word
);

    logic [mcasr_pkg::SAMPLE_BITS-1:0] r_word;

    assign o_word = r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_word <= '0;
        end else if (i_ctl.shift) begin
            r_word <= {r_word[mcasr_pkg::SAMPLE_BITS-2:0], i_bit};
        end
    end

endmodule

// ===== src/mcasr_seq.sv =====
// Tick sequencer: setup wait, clock pulse train, sample strobes and read end.
module mcasr_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mcasr_pkg::t_cfg                    i_cfg,
    input  logic                               i_accept,
    input  logic [mcasr_pkg::LINE_BITS-1:0]    i_lines,
    input  logic                               i_rd,
    input  logic                               i_md,
    output mcasr_pkg::t_lane_ctl               o_lane_ctl,
    output mcasr_pkg::t_tick_res               o_res
);

    localparam int TB = mcasr_pkg::TIMER_BITS;
    localparam int PB = mcasr_pkg::PULSE_BITS;
    localparam int CB = mcasr_pkg::CNT_BITS;

    mcasr_pkg::t_phase r_phase, n_phase, w_ph;
    logic [TB-1:0]     r_tc, n_tc, w_tc;
    logic [PB-1:0]     r_pc, n_pc, w_pc;
    logic              r_samp, n_samp;
    logic              r_clk, n_clk;

    logic [CB-1:0]     w_n;
    logic [TB-1:0]     w_hi, w_lo, w_setup, w_smp, w_at;
    logic [TB:0]       w_tc_inc;
    logic [PB-1:0]     w_trail, w_total;
    logic [mcasr_pkg::LINE_BITS-1:0] w_mask;
    mcasr_pkg::t_lane_ctl w_ctl;
    mcasr_pkg::t_tick_res w_res;

    always_comb begin
        if (i_cfg.channel_count == '0) begin
            w_n = CB'(1);
        end else if (i_cfg.channel_count > CB'(mcasr_pkg::MAX_CHANNELS)) begin
            w_n = CB'(mcasr_pkg::MAX_CHANNELS);
        end else begin
            w_n = i_cfg.channel_count;
        end
        w_hi    = (i_cfg.high_ticks == '0) ? TB'(1) : i_cfg.high_ticks;
        w_lo    = (i_cfg.low_ticks == '0) ? TB'(1) : i_cfg.low_ticks;
        w_setup = (i_cfg.setup_ticks == '0) ? TB'(1) : i_cfg.setup_ticks;
        w_smp   = (i_cfg.sample_ticks == '0) ? TB'(1) : i_cfg.sample_ticks;
        w_at    = (w_smp > w_hi - TB'(1)) ? w_hi - TB'(1) : w_smp;
        w_trail = (i_cfg.trailing_pulses == '0) ? PB'(1) : PB'(i_cfg.trailing_pulses);
        w_total = PB'(mcasr_pkg::SAMPLE_BITS) + w_trail;
        for (int i = 0; i < mcasr_pkg::LINE_BITS; i++) begin
            w_mask[i] = (i < mcasr_pkg::MAX_CHANNELS) && (CB'(i) < w_n);
        end
    end

    assign w_tc_inc = {1'b0, r_tc} + (TB+1)'(1);

    always_comb begin
        w_ph = r_phase;
        w_tc = r_tc;
        w_pc = r_pc;
        unique case (r_phase)
            mcasr_pkg::PH_SETUP: begin
                if (w_tc_inc >= {1'b0, w_setup}) begin
                    w_ph = mcasr_pkg::PH_HIGH;
                    w_tc = '0;
                end else begin
                    w_tc = w_tc_inc[TB-1:0];
                end
            end
            mcasr_pkg::PH_HIGH: begin
                if (w_tc_inc >= {1'b0, w_hi}) begin
                    w_ph = mcasr_pkg::PH_LOW;
                    w_tc = '0;
                end else begin
                    w_tc = w_tc_inc[TB-1:0];
                end
            end
            mcasr_pkg::PH_LOW: begin
                if (w_tc_inc >= {1'b0, w_lo}) begin
                    w_ph = mcasr_pkg::PH_HIGH;
                    w_tc = '0;
                    w_pc = r_pc + PB'(1);
                end else begin
                    w_tc = w_tc_inc[TB-1:0];
                end
            end
            default: ;
        endcase

        n_phase = w_ph;
        n_tc    = w_tc;
        n_pc    = w_pc;
        n_samp  = r_samp;
        n_clk   = r_clk;
        w_ctl   = '0;
        w_res.status = mcasr_pkg::ST_PLAIN;
        w_res.burst  = 1'b0;
        w_res.n      = w_n;
        w_res.busy   = 1'b1;

        unique case (w_ph)
            mcasr_pkg::PH_IDLE: begin
                n_clk = 1'b0;
                w_res.busy = 1'b0;
                if (i_rd && ((i_lines & w_mask) != '0)) begin
                    w_res.status = mcasr_pkg::ST_REFUSED;
                end else if (i_rd || i_md) begin
                    n_samp     = i_rd;
                    n_phase    = mcasr_pkg::PH_SETUP;
                    n_tc       = '0;
                    n_pc       = '0;
                    w_ctl.clear = 1'b1;
                    w_res.busy = 1'b1;
                end
            end
            mcasr_pkg::PH_SETUP: begin
                n_clk = 1'b0;
            end
            mcasr_pkg::PH_HIGH: begin
                n_clk = 1'b1;
                w_ctl.shift = r_samp && (w_pc < PB'(mcasr_pkg::SAMPLE_BITS)) && (w_tc == w_at);
            end
            mcasr_pkg::PH_LOW: begin
                n_clk = 1'b0;
                if (({1'b0, w_tc} + (TB+1)'(1) >= {1'b0, w_lo}) &&
                    ({1'b0, w_pc} + (PB+1)'(1) >= {1'b0, w_total})) begin
                    n_phase    = mcasr_pkg::PH_IDLE;
                    n_tc       = '0;
                    n_pc       = '0;
                    w_res.busy = 1'b0;
                    if (r_samp) begin
                        n_samp       = 1'b0;
                        w_res.burst  = 1'b1;
                        w_res.status = mcasr_pkg::ST_WORD;
                    end
                end
            end
            default: ;
        endcase
        w_res.serial_clock = n_clk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mcasr_pkg::PH_IDLE;
            r_tc    <= '0;
            r_pc    <= '0;
            r_samp  <= 1'b0;
            r_clk   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tc    <= n_tc;
            r_pc    <= n_pc;
            r_samp  <= n_samp;
            r_clk   <= n_clk;
        end
    end

    assign o_lane_ctl.clear = i_accept && w_ctl.clear;
    assign o_lane_ctl.shift = i_accept && w_ctl.shift;
    assign o_res            = w_res;

endmodule

// ===== src/mcasr_out.sv =====
// Output merge stage: result register and channel burst over the lane words.
`include "assert_macros.svh"

module mcasr_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  mcasr_pkg::t_tick_res                i_res,
    input  logic [mcasr_pkg::SAMPLE_BITS-1:0]   i_words [mcasr_pkg::MAX_CHANNELS],
    output logic                                o_s_ready,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mcasr_pkg::M_TDATA_W-1:0]     o_tdata,
    output logic [mcasr_pkg::M_TUSER_W-1:0]     o_tuser,
    output logic                                o_tlast
);

    localparam int CHB = mcasr_pkg::CH_BITS;
    localparam int CB  = mcasr_pkg::CNT_BITS;
    localparam int PAD = mcasr_pkg::M_TDATA_W - mcasr_pkg::SAMPLE_BITS - CHB - 2;

    logic                              r_valid, n_valid;
    logic                              r_burst, n_burst;
    logic [CHB-1:0]                    r_next_ch, n_next_ch;
    logic [CB-1:0]                     r_n, n_n;
    logic                              r_clk, n_clk;
    logic                              r_busy, n_busy;
    mcasr_pkg::t_status                r_status, n_status;
    logic [CHB-1:0]                    r_ch, n_ch;
    logic [mcasr_pkg::SAMPLE_BITS-1:0] r_conv, n_conv;
    logic                              r_last, n_last;
    logic                              w_take;

    assign w_take    = r_valid && i_ready;
    assign o_s_ready = !r_burst && (!r_valid || i_ready);

    always_comb begin
        n_valid   = r_valid;
        n_burst   = r_burst;
        n_next_ch = r_next_ch;
        n_n       = r_n;
        n_clk     = r_clk;
        n_busy    = r_busy;
        n_status  = r_status;
        n_ch      = r_ch;
        n_conv    = r_conv;
        n_last    = r_last;
        if (w_take) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid  = 1'b1;
            n_clk    = i_res.serial_clock;
            n_busy   = i_res.busy;
            n_status = i_res.status;
            n_ch     = '0;
            n_conv   = '0;
            n_last   = 1'b1;
            n_burst  = 1'b0;
            n_n      = i_res.n;
            if (i_res.burst) begin
                n_conv    = i_words[0];
                n_last    = (i_res.n == CB'(1));
                n_burst   = (i_res.n != CB'(1));
                n_next_ch = CHB'(1);
            end
        end else if (w_take && r_burst) begin
            n_valid   = 1'b1;
            n_ch      = r_next_ch;
            n_conv    = i_words[r_next_ch];
            n_last    = (CB'(r_next_ch) + CB'(1) == r_n);
            n_burst   = !n_last;
            n_next_ch = r_next_ch + CHB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_burst <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_burst <= n_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next_ch <= n_next_ch;
        r_n       <= n_n;
        r_clk     <= n_clk;
        r_busy    <= n_busy;
        r_status  <= n_status;
        r_ch      <= n_ch;
        r_conv    <= n_conv;
        r_last    <= n_last;
    end

    assign o_valid = r_valid;
    assign o_tdata = {{PAD{1'b0}}, r_conv, r_ch, r_busy, r_clk};
    assign o_tuser = r_status;
    assign o_tlast = r_last;

    `MCASR_ASSERT(a_burst_holds_word, i_clk, i_rst_n, r_burst |-> (r_valid && r_status == mcasr_pkg::ST_WORD), "burst pending without a conversion word in the output register")
    `MCASR_ASSERT(a_word_channel_in_range, i_clk, i_rst_n, (r_valid && r_status == mcasr_pkg::ST_WORD) |-> (CB'(r_ch) < r_n), "conversion word channel beyond active count")
    `MCASR_ASSERT_NEVER(a_last_with_burst, i_clk, i_rst_n, r_valid && r_last && r_burst, "last word marked while more words pending")
    `MCASR_ASSERT_NEVER(a_load_in_burst, i_clk, i_rst_n, i_load && r_burst, "new request loaded during a channel burst")
    `MCASR_ASSERT(a_load_has_room, i_clk, i_rst_n, i_load |-> (!r_valid || i_ready), "result loaded over a pending result")

endmodule

// ===== src/multi_channel_adc_serial_reader.sv =====
// Top level of the multi-channel converter serial readout sequencer.
// The result of an accepted request appears on the master side in the next cycle.
// Throughput: one request per cycle while the master side keeps up; the request that
// ends a read yields a word per active channel, and the slave side holds off meanwhile.
// Reset (synchronous, active low) returns the sequencer to idle with the clock line low,
// empties the output stage and loads the registers with their reset values.
module multi_channel_adc_serial_reader (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mcasr_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [mcasr_pkg::DATA_BITS-1:0]     pwdata,
    output logic [mcasr_pkg::DATA_BITS-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // data_lines[7:0], read_request[8], mode_request[9], zero fill [15:10]
    input  logic [mcasr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // serial_clock[0], busy_res[1], channel[4:2], conversion[28:5], zero fill [31:29]
    output logic [mcasr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // status[1:0]
    output logic [mcasr_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast
);

    mcasr_pkg::t_cfg                    w_cfg;
    mcasr_pkg::t_lane_ctl               w_lane_ctl;
    mcasr_pkg::t_tick_res               w_res;
    logic                               w_accept;
    logic [mcasr_pkg::LINE_BITS-1:0]    w_lines;
    logic [mcasr_pkg::SAMPLE_BITS-1:0]  w_words [mcasr_pkg::MAX_CHANNELS];

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_lines  = s_axis_tdata[mcasr_pkg::LINE_BITS-1:0];

    mcasr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mcasr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_accept   (w_accept),
        .i_lines    (w_lines),
        .i_rd       (s_axis_tdata[mcasr_pkg::LINE_BITS]),
        .i_md       (s_axis_tdata[mcasr_pkg::LINE_BITS+1]),
        .o_lane_ctl (w_lane_ctl),
        .o_res      (w_res)
    );

    for (genvar g = 0; g < mcasr_pkg::MAX_CHANNELS; g++) begin : g_lane
        mcasr_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_lane_ctl),
            .i_bit  (w_lines[g]),
            .o_word (w_words[g])
        );
    end

    mcasr_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_accept),
        .i_res     (w_res),
        .i_words   (w_words),
        .o_s_ready (s_axis_tready),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the multi-channel converter serial readout sequencer.
typedef struct {
    logic                 serial_clock;
    logic                 busy;
    mcasr_pkg::t_status   status;
    logic [2:0]           channel;
    logic [23:0]          conversion;
    logic                 last;
} t_readout_item;

class t_readout_tracker;
    mcasr_pkg::t_cfg   regs;
    mcasr_pkg::t_phase phase;
    int                ticks;
    int                pulses;
    bit                sampling;
    bit                clock_level;
    logic [23:0]       words [mcasr_pkg::MAX_CHANNELS];
    t_readout_item     tick_results [$];
    int                requests_taken;
    int                results_seen;
    int                errors;

    function void reset_state();
        regs.channel_count   = 4'd1;
        regs.high_ticks      = 16'd3;
        regs.low_ticks       = 16'd3;
        regs.sample_ticks    = 16'd2;
        regs.setup_ticks     = 16'd2;
        regs.trailing_pulses = 2'd3;
        phase       = mcasr_pkg::PH_IDLE;
        ticks       = 0;
        pulses      = 0;
        sampling    = 1'b0;
        clock_level = 1'b0;
        foreach (words[i]) words[i] = '0;
        tick_results.delete();
    endfunction

    function void set_reg(mcasr_pkg::t_reg_idx idx, logic [31:0] value);
        case (idx)
            mcasr_pkg::REG_CHANNEL_COUNT:   regs.channel_count   = value[3:0];
            mcasr_pkg::REG_HIGH_TICKS:      regs.high_ticks      = value[15:0];
            mcasr_pkg::REG_LOW_TICKS:       regs.low_ticks       = value[15:0];
            mcasr_pkg::REG_SAMPLE_TICKS:    regs.sample_ticks    = value[15:0];
            mcasr_pkg::REG_SETUP_TICKS:     regs.setup_ticks     = value[15:0];
            mcasr_pkg::REG_TRAILING_PULSES: regs.trailing_pulses = value[1:0];
            default: ;
        endcase
    endfunction

    function int active_count();
        int n;
        n = regs.channel_count;
        if (n < 1) n = 1;
        if (n > mcasr_pkg::MAX_CHANNELS) n = mcasr_pkg::MAX_CHANNELS;
        return n;
    endfunction

    function int at_least_one(logic [15:0] v);
        return (v == 16'd0) ? 1 : int'(v);
    endfunction

    function void push(mcasr_pkg::t_status st, int ch, logic [23:0] conv, bit last);
        t_readout_item r;
        r.serial_clock = clock_level;
        r.busy         = (phase != mcasr_pkg::PH_IDLE);
        r.status       = st;
        r.channel      = 3'(ch);
        r.conversion   = conv;
        r.last         = last;
        tick_results.push_back(r);
    endfunction

    function void take_tick(logic [7:0] lines, logic rd, logic md);
        int         n;
        int         hi;
        int         lo;
        int         total;
        int         at;
        int         i;
        logic [7:0] act;
        n     = active_count();
        hi    = at_least_one(regs.high_ticks);
        lo    = at_least_one(regs.low_ticks);
        total = mcasr_pkg::SAMPLE_BITS + at_least_one(16'(regs.trailing_pulses));
        act   = 8'((1 << n) - 1);
        case (phase)
            mcasr_pkg::PH_SETUP: begin
                ticks++;
                if (ticks >= at_least_one(regs.setup_ticks)) begin
                    phase = mcasr_pkg::PH_HIGH;
                    ticks = 0;
                end
            end
            mcasr_pkg::PH_HIGH: begin
                ticks++;
                if (ticks >= hi) begin
                    phase = mcasr_pkg::PH_LOW;
                    ticks = 0;
                end
            end
            mcasr_pkg::PH_LOW: begin
                ticks++;
                if (ticks >= lo) begin
                    pulses++;
                    phase = mcasr_pkg::PH_HIGH;
                    ticks = 0;
                end
            end
            default: ;
        endcase
        case (phase)
            mcasr_pkg::PH_IDLE: begin
                clock_level = 1'b0;
                if (rd || md) requests_taken++;
                if (rd && (lines & act) != 8'd0) begin
                    push(mcasr_pkg::ST_REFUSED, 0, 24'd0, 1'b1);
                    return;
                end
                if (rd) sampling = 1'b1;
                else if (md) sampling = 1'b0;
                if (rd || md) begin
                    phase  = mcasr_pkg::PH_SETUP;
                    ticks  = 0;
                    pulses = 0;
                    foreach (words[j]) words[j] = '0;
                end
                push(mcasr_pkg::ST_PLAIN, 0, 24'd0, 1'b1);
            end
            mcasr_pkg::PH_SETUP: begin
                clock_level = 1'b0;
                push(mcasr_pkg::ST_PLAIN, 0, 24'd0, 1'b1);
            end
            mcasr_pkg::PH_HIGH: begin
                at = at_least_one(regs.sample_ticks);
                if (at > hi - 1) at = hi - 1;
                clock_level = 1'b1;
                if (sampling && pulses < mcasr_pkg::SAMPLE_BITS && ticks == at) begin
                    for (i = 0; i < n; i++) words[i] = {words[i][22:0], lines[i]};
                end
                push(mcasr_pkg::ST_PLAIN, 0, 24'd0, 1'b1);
            end
            default: begin
                clock_level = 1'b0;
                if (ticks + 1 >= lo && pulses + 1 >= total) begin
                    phase  = mcasr_pkg::PH_IDLE;
                    ticks  = 0;
                    pulses = 0;
                    if (sampling) begin
                        sampling = 1'b0;
                        for (i = 0; i < n; i++)
                            push(mcasr_pkg::ST_WORD, i, words[i], i + 1 == n);
                        return;
                    end
                end
                push(mcasr_pkg::ST_PLAIN, 0, 24'd0, 1'b1);
            end
        endcase
    endfunction

    task report_mismatch(string msg);
        $display("result %0d: %s", results_seen, msg);
        errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task match_output(logic [31:0] data, logic [1:0] user, logic last);
        t_readout_item want;
        results_seen++;
        if (tick_results.size() == 0) begin
            report_mismatch($sformatf("unrequested result %h/%h/%b", data, user, last));
            return;
        end
        want = tick_results.pop_front();
        compare_field("serial_clock", 32'(data[0]), 32'(want.serial_clock));
        compare_field("busy_res", 32'(data[1]), 32'(want.busy));
        compare_field("channel", 32'(data[4:2]), 32'(want.channel));
        compare_field("conversion", 32'(data[28:5]), 32'(want.conversion));
        compare_field("status", 32'(user), 32'(want.status));
        compare_field("last", 32'(last), 32'(want.last));
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 500;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [mcasr_pkg::ADDR_BITS-1:0] paddr         = '0;
    logic [mcasr_pkg::DATA_BITS-1:0] pwdata        = '0;
    logic [mcasr_pkg::DATA_BITS-1:0] prdata;
    logic                            pready;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [mcasr_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [mcasr_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [mcasr_pkg::M_TUSER_W-1:0] m_axis_tuser;
    logic                            m_axis_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;

    t_readout_tracker tracker = new();

    multi_channel_adc_serial_reader dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("multi_channel_adc_serial_reader: mismatch");
        $finish;
    end

    task automatic write_reg(mcasr_pkg::t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic configure(logic [3:0] cnt, logic [15:0] hi, logic [15:0] lo,
                             logic [15:0] samp, logic [15:0] setup, logic [1:0] trail);
        write_reg(mcasr_pkg::REG_CHANNEL_COUNT, 32'(cnt));
        write_reg(mcasr_pkg::REG_HIGH_TICKS, 32'(hi));
        write_reg(mcasr_pkg::REG_LOW_TICKS, 32'(lo));
        write_reg(mcasr_pkg::REG_SAMPLE_TICKS, 32'(samp));
        write_reg(mcasr_pkg::REG_SETUP_TICKS, 32'(setup));
        write_reg(mcasr_pkg::REG_TRAILING_PULSES, 32'(trail));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_tick(logic [7:0] lines, logic rd, logic md);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {6'b0, md, rd, lines};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_tick(lines, rd, md);
        @(negedge i_clk);
    endtask

    // finish any running sequence, then drain the output side
    task automatic settle();
        while (tracker.phase != mcasr_pkg::PH_IDLE)
            send_tick(8'($urandom), ($urandom_range(7) == 0), ($urandom_range(7) == 0));
        s_axis_tvalid <= 1'b0;
        while (tracker.tick_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_tick(bit only_refused);
        logic [7:0] lines;
        logic [7:0] act;
        logic       rd;
        logic       md;
        int         pick;
        int         n;
        lines = 8'($urandom);
        rd    = 1'b0;
        md    = 1'b0;
        if (tracker.phase == mcasr_pkg::PH_IDLE) begin
            n    = tracker.active_count();
            act  = 8'((1 << n) - 1);
            pick = only_refused ? ($urandom_range(1) ? 55 : 90) : $urandom_range(99);
            if (pick < 50) begin
                rd    = 1'b1;
                lines = lines & ~act;
            end else if (pick < 60) begin
                rd    = 1'b1;
                lines = lines | (8'd1 << $urandom_range(n - 1));
            end else if (pick < 72) begin
                md = 1'b1;
            end else if (pick < 78) begin
                rd = 1'b1;
                md = 1'b1;
                if ($urandom_range(1)) lines = lines & ~act;
            end
        end else begin
            rd = ($urandom_range(7) == 0);
            md = ($urandom_range(7) == 0);
        end
        send_tick(lines, rd, md);
    endtask

    task automatic run_phase(logic [3:0] cnt, logic [15:0] hi, logic [15:0] lo,
                             logic [15:0] samp, logic [15:0] setup, logic [1:0] trail,
                             int send_pct, int recv_pct, int goal, bit only_refused);
        int start;
        configure(cnt, hi, lo, samp, setup, trail);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = tracker.requests_taken;
        while (tracker.requests_taken - start < goal) random_tick(only_refused);
        settle();
    endtask

    initial begin
        tracker.reset_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        configure(4'd8, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
        send_tick(8'h00, 1'b0, 1'b0);
        send_tick(8'h80, 1'b1, 1'b0);
        send_tick(8'h01, 1'b1, 1'b1);
        hold_request = 1'b1;
        send_tick(8'h00, 1'b1, 1'b1);
        settle();

        run_phase(4'd3, 16'd2, 16'd1, 16'd5, 16'd3, 2'd2, 77, 0, 4, 1'b1);

        configure(4'd15, 16'd1, 16'd1, 16'd5, 16'd3, 2'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        send_tick(8'h00, 1'b1, 1'b0);
        settle();

        configure(4'd0, 16'd1, 16'd1, 16'd0, 16'd1, 2'd1);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        send_tick(8'hFF, 1'b0, 1'b1);
        settle();
        send_tick(8'h01, 1'b1, 1'b0);
        settle();

        recv_stall_pct = 0;
        repeat (20) @(negedge i_clk);
        if (tracker.tick_results.size() != 0)
            tracker.report_mismatch("results still pending at the end");
        if (tracker.errors == 0)
            $display("multi_channel_adc_serial_reader: match");
        else
            $display("multi_channel_adc_serial_reader: mismatch");
        $finish;
    end
endmodule
